>>> hw/rtl/lfsa_pkg.sv
// Shared codes, field widths and types for the lowest-free-slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package lfsa_pkg;

   // Port field widths.
   localparam int ACTION_W     = 2;
   localparam int INDEX_W      = 11;
   localparam int LOAD_W       = 16;
   localparam int CLIENT_OUT_W = 11;
   localparam int SLOT_OUT_W   = 7;
   localparam int CHARGE_W     = 32;
   localparam int TOTAL_W      = 63;
   localparam int CSR_W        = 8;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [1:0]          status_type;
   typedef logic [TOTAL_W-1:0]  total_type;

   localparam action_type ACT_LOAD_RATE   = 2'd0;
   localparam action_type ACT_LOAD_WEIGHT = 2'd1;
   localparam action_type ACT_ARRIVE      = 2'd2;
   localparam action_type ACT_DEPART      = 2'd3;

   localparam status_type ST_NONE  = 2'd0;
   localparam status_type ST_GRANT = 2'd1;
   localparam status_type ST_DROP  = 2'd2;

   localparam logic [CSR_W-1:0] CSR_RESET = 8'd128;
   localparam total_type        TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

`default_nettype wire

>>> hw/rtl/lowest_free_slot_allocator_fifo_wait.sv
// Lowest-free-slot allocator with a FIFO waitlist and a saturating charge total.
//
//   channel   ports                          handshake
//   -------   -----------------------------  ------------------------------------
//   request   req_action/target_index/load   taken when start is high, busy low
//   result    rsp_status ... rsp_total       one cycle, marked by rsp_strobe
//   register  csr_write_enable/data          written on any edge with enable high, reset low
//
// Each request gives exactly one result, shown in the first cycle that busy is low
// again. Loads, ignored requests, drops and waitlist joins end in the lookup step;
// a departure goes on to a free step; a grant, for an arrival or for a departure
// that gives the waitlist head a free slot, then runs the grant, multiply and add steps.
// The weight and rate reads, the multiply and the saturating add are registered steps.
// After reset the client table is swept clear, with busy high.
// The result register frees the request side at once; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_slot_allocator_fifo_wait #(
   parameter int SLOTS      = 128,
   parameter int CLIENTS    = 2048,
   parameter int VALUE_BITS = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   output logic                                   busy,
   input  wire  [lfsa_pkg::ACTION_W-1:0]          req_action,
   input  wire  [lfsa_pkg::INDEX_W-1:0]           req_target_index,
   input  wire  [lfsa_pkg::LOAD_W-1:0]            req_load_value,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_status,
   output logic [lfsa_pkg::CLIENT_OUT_W-1:0]      rsp_assigned_client,
   output logic [lfsa_pkg::SLOT_OUT_W-1:0]        rsp_assigned_slot,
   output logic [lfsa_pkg::CHARGE_W-1:0]          rsp_charge,
   output logic [lfsa_pkg::TOTAL_W-1:0]           rsp_total_charge,
   input  wire                                    csr_write_enable,
   input  wire  [lfsa_pkg::CSR_W-1:0]             csr_write_data
);

   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int CLI_W   = $clog2(CLIENTS);
   localparam int CNT_W   = CLI_W + 1;
   localparam int TAIL_W  = CLI_W + 2;
   localparam int ENTRY_W = SLOT_W + 2;
   localparam int PROD_W  = 2 * VALUE_BITS;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LOOK  = 3'd2;
   localparam logic [2:0] S_FREE  = 3'd3;
   localparam logic [2:0] S_GRANT = 3'd4;
   localparam logic [2:0] S_MUL   = 3'd5;
   localparam logic [2:0] S_ADD   = 3'd6;

   // Client entry: parked bit, waiting bit, slot number.
   logic [ENTRY_W-1:0]    client_mem [CLIENTS];
   logic [CLI_W-1:0]      wait_mem   [CLIENTS];
   logic [VALUE_BITS-1:0] weight_mem [CLIENTS];
   logic [VALUE_BITS-1:0] rate_mem   [SLOTS];

   logic [2:0]              state_ff, state_in;
   logic [CLI_W-1:0]        clr_ff, clr_in;
   logic [lfsa_pkg::ACTION_W-1:0] act_ff;
   logic [CLI_W-1:0]        cli_ff;
   logic                    cli_ok_ff;
   logic [ENTRY_W-1:0]      entry_rd_ff;
   logic [CLI_W-1:0]        head_rd_ff;
   logic [CLI_W-1:0]        gcli_ff, gcli_in;
   logic [SLOT_W-1:0]       gslot_ff, gslot_in;
   logic [VALUE_BITS-1:0]   weight_rd_ff, rate_rd_ff;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [SLOTS-1:0]        slot_busy_ff, slot_busy_in;
   logic [CLI_W-1:0]        whead_ff, whead_in;
   logic [CNT_W-1:0]        wcount_ff, wcount_in;
   lfsa_pkg::total_type     revenue_ff, revenue_in;
   logic [lfsa_pkg::CSR_W-1:0] csr_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   lfsa_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [lfsa_pkg::CLIENT_OUT_W-1:0] rsp_client_ff, rsp_client_in;
   logic [lfsa_pkg::SLOT_OUT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [lfsa_pkg::CHARGE_W-1:0]     rsp_charge_ff, rsp_charge_in;
   lfsa_pkg::total_type               rsp_total_ff, rsp_total_in;

   logic                    accept;
   logic [31:0]             idx32, val32, gcli32, gslot32;
   logic [CLI_W-1:0]        req_cli;
   logic [SLOT_W-1:0]       req_slot;
   logic                    req_slot_ok, req_cli_ok;
   logic                    free_found;
   logic [SLOT_W-1:0]       free_idx;
   logic [TAIL_W-1:0]       tail_sum;
   logic [CLI_W-1:0]        tail;
   logic [CLI_W-1:0]        head_next;
   logic                    entry_parked, entry_waiting;
   logic [SLOT_W-1:0]       entry_slot;
   logic [63:0]             sum64, prod64;
   lfsa_pkg::total_type     sat_total;
   logic                    cm_we;
   logic [CLI_W-1:0]        cm_waddr;
   logic [ENTRY_W-1:0]      cm_wdata;
   logic                    fifo_we;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign idx32       = 32'(req_target_index);
   assign val32       = 32'(req_load_value);
   assign req_cli     = idx32[CLI_W-1:0];
   assign req_slot    = idx32[SLOT_W-1:0];
   assign req_slot_ok = (idx32 < 32'(SLOTS));
   assign req_cli_ok  = (idx32 < 32'(CLIENTS));

   assign entry_parked  = entry_rd_ff[SLOT_W+1];
   assign entry_waiting = entry_rd_ff[SLOT_W];
   assign entry_slot    = entry_rd_ff[SLOT_W-1:0];

   // Lowest usable free slot; the scan runs downward so the lowest hit wins.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!slot_busy_ff[i] && (i < int'(csr_ff))) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // Tail of the circular waitlist and the head after a pop.
   always_comb begin
      tail_sum = TAIL_W'(whead_ff) + TAIL_W'(wcount_ff);
      if (tail_sum >= TAIL_W'(CLIENTS)) begin
         tail_sum = tail_sum - TAIL_W'(CLIENTS);
      end
      tail = tail_sum[CLI_W-1:0];
      if (whead_ff == CLI_W'(CLIENTS - 1)) begin
         head_next = '0;
      end else begin
         head_next = whead_ff + 1'b1;
      end
   end

   assign prod64    = 64'(prod_ff);
   assign sum64     = {1'b0, revenue_ff} + prod64;
   assign sat_total = sum64[63] ? lfsa_pkg::TOTAL_MAX : sum64[62:0];
   assign gcli32    = 32'(gcli_ff);
   assign gslot32   = 32'(gslot_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      gcli_in       = gcli_ff;
      gslot_in      = gslot_ff;
      prod_in       = prod_ff;
      slot_busy_in  = slot_busy_ff;
      whead_in      = whead_ff;
      wcount_in     = wcount_ff;
      revenue_in    = revenue_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_client_in = rsp_client_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_charge_in = rsp_charge_ff;
      rsp_total_in  = rsp_total_ff;
      cm_we         = 1'b0;
      cm_waddr      = cli_ff;
      cm_wdata      = '0;
      fifo_we       = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            cm_we    = 1'b1;
            cm_waddr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == CLI_W'(CLIENTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            // Unless a grant or free step follows, the request ends here with its result.
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = lfsa_pkg::ST_NONE;
            rsp_client_in = '0;
            rsp_slot_in   = '0;
            rsp_charge_in = '0;
            rsp_total_in  = revenue_ff;
            case (act_ff)
               lfsa_pkg::ACT_ARRIVE: begin
                  if (cli_ok_ff && !entry_parked && !entry_waiting) begin
                     if (free_found) begin
                        gslot_in = free_idx;
                        state_in = S_GRANT;
                        rsp_valid_in = 1'b0;
                        if (wcount_ff == '0) begin
                           gcli_in = cli_ff;
                        end else begin
                           // Head is served; the newcomer goes to the tail.
                           gcli_in  = head_rd_ff;
                           whead_in = head_next;
                           fifo_we  = 1'b1;
                           cm_we    = 1'b1;
                           cm_wdata = {1'b0, 1'b1, entry_slot};
                        end
                     end else if (wcount_ff >= CNT_W'(CLIENTS)) begin
                        rsp_status_in = lfsa_pkg::ST_DROP;
                     end else begin
                        fifo_we   = 1'b1;
                        cm_we     = 1'b1;
                        cm_wdata  = {1'b0, 1'b1, entry_slot};
                        wcount_in = wcount_ff + 1'b1;
                     end
                  end
               end
               lfsa_pkg::ACT_DEPART: begin
                  if (cli_ok_ff && entry_parked) begin
                     cm_we        = 1'b1;
                     cm_wdata     = {1'b0, 1'b0, entry_slot};
                     slot_busy_in[entry_slot] = 1'b0;
                     rsp_valid_in = 1'b0;
                     state_in     = S_FREE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_FREE: begin
            if ((wcount_ff != '0) && free_found) begin
               gcli_in   = head_rd_ff;
               gslot_in  = free_idx;
               whead_in  = head_next;
               wcount_in = wcount_ff - 1'b1;
               state_in  = S_GRANT;
            end else begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = lfsa_pkg::ST_NONE;
               rsp_client_in = '0;
               rsp_slot_in   = '0;
               rsp_charge_in = '0;
               rsp_total_in  = revenue_ff;
            end
         end
         S_GRANT: begin
            cm_we    = 1'b1;
            cm_waddr = gcli_ff;
            cm_wdata = {1'b1, 1'b0, gslot_ff};
            slot_busy_in[gslot_ff] = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(weight_rd_ff) * PROD_W'(rate_rd_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            revenue_in    = sat_total;
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = lfsa_pkg::ST_GRANT;
            rsp_client_in = gcli32[lfsa_pkg::CLIENT_OUT_W-1:0];
            rsp_slot_in   = gslot32[lfsa_pkg::SLOT_OUT_W-1:0];
            rsp_charge_in = prod64[lfsa_pkg::CHARGE_W-1:0];
            rsp_total_in  = sat_total;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         slot_busy_ff <= '0;
         whead_ff     <= '0;
         wcount_ff    <= '0;
         revenue_ff   <= '0;
         csr_ff       <= lfsa_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         slot_busy_ff <= slot_busy_in;
         whead_ff     <= whead_in;
         wcount_ff    <= wcount_in;
         revenue_ff   <= revenue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            csr_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff    <= req_action;
         cli_ff    <= req_cli;
         cli_ok_ff <= req_cli_ok;
      end
      gcli_ff       <= gcli_in;
      gslot_ff      <= gslot_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_client_ff <= rsp_client_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // Client table: written by the sweep and the update steps, read at request time.
   always_ff @(posedge clock) begin
      if (cm_we) begin
         client_mem[cm_waddr] <= cm_wdata;
      end
      if (accept) begin
         entry_rd_ff <= client_mem[req_cli];
      end
   end

   // Waitlist storage.
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         wait_mem[tail] <= cli_ff;
      end
      if (accept) begin
         head_rd_ff <= wait_mem[whead_ff];
      end
   end

   // Weight and rate tables are loaded straight from the request.
   always_ff @(posedge clock) begin
      if (accept && (req_action == lfsa_pkg::ACT_LOAD_WEIGHT) && req_cli_ok) begin
         weight_mem[req_cli] <= val32[VALUE_BITS-1:0];
      end
      if (state_ff == S_GRANT) begin
         weight_rd_ff <= weight_mem[gcli_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_action == lfsa_pkg::ACT_LOAD_RATE) && req_slot_ok) begin
         rate_mem[req_slot] <= val32[VALUE_BITS-1:0];
      end
      if (state_ff == S_GRANT) begin
         rate_rd_ff <= rate_mem[gslot_ff];
      end
   end

   assign rsp_strobe          = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_assigned_client = rsp_client_ff;
   assign rsp_assigned_slot   = rsp_slot_ff;
   assign rsp_charge          = rsp_charge_ff;
   assign rsp_total_charge    = rsp_total_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lfsa_checker.sv
// Port-level checks for the slot allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lfsa_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                start,
   input wire                                busy,
   input wire                                rsp_strobe,
   input wire [1:0]                          rsp_status,
   input wire [lfsa_pkg::CLIENT_OUT_W-1:0]   rsp_assigned_client,
   input wire [lfsa_pkg::SLOT_OUT_W-1:0]     rsp_assigned_slot,
   input wire [lfsa_pkg::CHARGE_W-1:0]       rsp_charge,
   input wire [lfsa_pkg::TOTAL_W-1:0]        rsp_total_charge
);

   // Reset starts the table sweep, so no request can be taken right after it.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> busy && !rsp_strobe)
      else $error("busy low or result seen after reset");

   // A request never finishes in the cycle after it is taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("request finished without a lookup cycle");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   // Only a grant carries a client, slot and charge.
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != lfsa_pkg::ST_GRANT)) |->
         (rsp_assigned_client == '0) && (rsp_assigned_slot == '0) && (rsp_charge == '0))
      else $error("fields set on a result without a grant");

   a_total_covers_charge: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == lfsa_pkg::ST_GRANT)) |->
         (rsp_total_charge >= lfsa_pkg::TOTAL_W'(rsp_charge)))
      else $error("running total below the charge just added");

endmodule

bind lowest_free_slot_allocator_fifo_wait lfsa_checker u_lfsa_checker (.*);

`default_nettype wire
